### rtl/core/page_offset_hint_decoder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page offset hint decoder
// Macros that wrap concurrent assertions on clk with arst_n as disable.
// ----------------------------------------------------------------------------
`ifndef PAGE_OFFSET_HINT_DECODER_DEFINES_SVH
`define PAGE_OFFSET_HINT_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// Property prop must hold at every clock edge outside reset.
`define POHD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition cond must never be true at a clock edge outside reset.
`define POHD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define POHD_ASSERT(lbl, prop, msg)
`define POHD_NEVER(lbl, cond, msg)
`endif
`endif

### rtl/core/pohd_pkg.sv
// ----------------------------------------------------------------------------
// Page offset hint decoder package
// Shared constants, codes, types and the header width table.
// ----------------------------------------------------------------------------
`default_nettype none

package pohd_pkg;

	// Default sizes.
	localparam int MAX_PAGES_DEF   = 1024;
	localparam int BUFFER_BITS_DEF = 64;

	// Request codes.
	localparam logic [1:0] REQ_BYTE    = 2'd0;
	localparam logic [1:0] REQ_NEXT    = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_FIELD     = 3'd0;
	localparam logic [2:0] ST_NEED_BYTE = 3'd1;
	localparam logic [2:0] ST_DONE      = 3'd2;
	localparam logic [2:0] ST_TAKEN     = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_BAD_WIDTH = 3'd5;

	// Section codes.
	localparam logic [2:0] SEC_HEADER  = 3'd0;
	localparam logic [2:0] SEC_OBJECTS = 3'd1;
	localparam logic [2:0] SEC_LENGTH  = 3'd2;
	localparam logic [2:0] SEC_REFCNT  = 3'd3;
	localparam logic [2:0] SEC_ID      = 3'd4;
	localparam logic [2:0] SEC_POS     = 3'd5;
	localparam logic [2:0] SEC_COFF    = 3'd6;
	localparam logic [2:0] SEC_CLEN    = 3'd7;

	// Number of header fields kept; the last header field is never read back.
	localparam int HDR_KEEP = 12;

	// Decoder sequencer states.
	typedef enum logic {
		DS_RUN,
		DS_FETCH
	} dec_state_t;

	// One result item.
	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  section;
		logic [9:0]  page_index;
		logic [15:0] ref_index;
		logic [31:0] value;
		logic [31:0] derived;
	} res_t;

	// Bit width of each fixed header field.
	function automatic logic [5:0] hdr_width(input logic [3:0] idx);
		logic [5:0] w;
		case (idx)
			4'd0, 4'd1, 4'd3, 4'd5, 4'd7: w = 6'd32;
			default: w = 6'd16;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### rtl/core/page_offset_hint_decoder.sv
// ----------------------------------------------------------------------------
// Page offset hint decoder
// Streams a page offset hint table in as bytes and returns one field per request.
// ----------------------------------------------------------------------------
// Each byte or field request yields one result, which leaves through a
// two-entry output buffer. The list of pages with shared references sits in
// a RAM with a registered read port, so no item is accepted during a list
// read, made on entering the shared id section and after the last reference
// of each page in the shared id and shared position sections; a second list
// read follows when the shared id section runs out of pages.
// Configuration writes are always accepted and must only be made while the
// block is idle.
`default_nettype none

module page_offset_hint_decoder #(
	parameter int MAX_PAGES   = pohd_pkg::MAX_PAGES_DEF,
	parameter int BUFFER_BITS = pohd_pkg::BUFFER_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	// Slave side.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic [1:0]  s_tuser,   // [1:0] req_type
	// Master side.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata,   // [2:0] section, [12:3] page_index,
	                                    // [28:13] ref_index, [60:29] value,
	                                    // [92:61] derived, rest zero
	output logic [2:0]       m_tuser    // [2:0] status
);
	import pohd_pkg::*;

	localparam logic [1:0] CFG_NUM_PAGES  = 2'd0;
	localparam logic [1:0] CFG_FIRST_OBJ  = 2'd1;
	localparam logic [1:0] CFG_HINT_OFF   = 2'd2;
	localparam logic [1:0] CFG_HINT_LEN   = 2'd3;

	logic [10:0] num_pages_q;
	logic [31:0] fpfo_q;
	logic [31:0] hoff_q;
	logic [31:0] hlen_q;
	logic        space;
	logic        push;
	res_t        push_res;
	res_t        m_res;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_pages_q <= 11'd1;
			fpfo_q      <= 32'd0;
			hoff_q      <= 32'd0;
			hlen_q      <= 32'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_NUM_PAGES: num_pages_q <= cfg_data[10:0];
				CFG_FIRST_OBJ: fpfo_q      <= cfg_data;
				CFG_HINT_OFF:  hoff_q      <= cfg_data;
				CFG_HINT_LEN:  hlen_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pohd_core #(
		.MAX_PAGES   (MAX_PAGES),
		.BUFFER_BITS (BUFFER_BITS)
	) u_core (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.num_pages               (num_pages_q),
		.first_page_first_object (fpfo_q),
		.hint_offset             (hoff_q),
		.hint_length             (hlen_q),
		.in_valid                (s_tvalid),
		.in_ready                (s_tready),
		.req_type                (s_tuser),
		.data_byte               (s_tdata),
		.space                   (space),
		.push                    (push),
		.push_res                (push_res)
	);

	pohd_res_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_res (push_res),
		.space    (space),
		.m_valid  (m_tvalid),
		.m_ready  (m_tready),
		.m_res    (m_res)
	);

	// Pack the result item onto the master side.
	assign m_tuser = m_res.status;
	assign m_tdata = {3'd0, m_res.derived, m_res.value, m_res.ref_index,
		m_res.page_index, m_res.section};

endmodule

`default_nettype wire

### rtl/core/pohd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pohd_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/pohd_res_fifo.sv
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry output register with skid stage between decoder and master side.
// ----------------------------------------------------------------------------
`default_nettype none

module pohd_res_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire pohd_pkg::res_t push_res,
	output logic               space,
	output logic               m_valid,
	input  wire logic          m_ready,
	output pohd_pkg::res_t     m_res
);
	import pohd_pkg::*;

	logic [1:0] cnt_q;
	res_t       front_q;
	res_t       skid_q;
	logic       pop;

	assign pop     = m_valid && m_ready;
	assign space   = (cnt_q != 2'd2);
	assign m_valid = (cnt_q != 2'd0);
	assign m_res   = front_q;

	// Occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Payload: front entry is what the master side sees.
	always_ff @(posedge clk) begin
		if (cnt_q == 2'd2) begin
			if (pop) begin
				front_q <= skid_q;
			end
		end else if (cnt_q == 2'd1) begin
			if (push && pop) begin
				front_q <= push_res;
			end else if (push) begin
				skid_q <= push_res;
			end
		end else if (push) begin
			front_q <= push_res;
		end
	end

endmodule

`default_nettype wire

### rtl/core/pohd_core.sv
// ----------------------------------------------------------------------------
// Hint table decoder core
// Bit buffer, field extraction, section sequencing and the shared-list walk.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_offset_hint_decoder_defines.svh"

module pohd_core #(
	parameter int MAX_PAGES   = pohd_pkg::MAX_PAGES_DEF,
	parameter int BUFFER_BITS = pohd_pkg::BUFFER_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [10:0]   num_pages,
	input  wire logic [31:0]   first_page_first_object,
	input  wire logic [31:0]   hint_offset,
	input  wire logic [31:0]   hint_length,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [1:0]    req_type,
	input  wire logic [7:0]    data_byte,
	input  wire logic          space,
	output logic               push,
	output pohd_pkg::res_t     push_res
);
	import pohd_pkg::*;

	localparam int CW  = $clog2(MAX_PAGES + 1);
	localparam int PCW = (CW > 4) ? CW : 4;
	localparam int AW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int FW  = $clog2(BUFFER_BITS + 1);
	localparam int EW  = PCW + 16;

	// Decoder state.
	logic [BUFFER_BITS-1:0] buf_q, buf_d;
	logic [FW-1:0]          fill_q, fill_d;
	logic [2:0]             sec_q, sec_d;
	logic [PCW-1:0]         pc_q, pc_d;
	logic [15:0]            ref_q, ref_d;
	logic [15:0]            cnt_q, cnt_d;
	logic [31:0]            hdr_q [0:HDR_KEEP-1];
	logic [31:0]            roff_q, roff_d;
	logic [31:0]            robj_q, robj_d;
	logic                   done_q, done_d;
	logic [CW-1:0]          lidx_q, lidx_d;
	logic [CW-1:0]          llen_q, llen_d;
	dec_state_t             st_q, st_d;
	logic                   byp_q;
	logic [EW-1:0]          byp_data_q;

	// Combinational working values.
	logic                   accept;
	logic [CW-1:0]          pages;
	logic [31:0]            w32;
	logic [5:0]             w6;
	logic [31:0]            base;
	logic [FW-1:0]          shamt;
	logic [BUFFER_BITS-1:0] shifted;
	logic [31:0]            mask;
	logic [31:0]            raw;
	logic [31:0]            val;
	logic                   hdr_we;
	logic                   mem_we;
	logic [EW-1:0]          mem_wdata;
	logic [EW-1:0]          mem_rdata;
	logic [EW-1:0]          list_rd;
	logic [PCW-1:0]         rd_page;
	logic [15:0]            rd_cnt;
	logic                   rd_ok;
	logic [FW-1:0]          fill_al;

	assign accept   = in_valid && in_ready;
	assign in_ready = (st_q == DS_RUN) && space;
	// A list entry written at the edge that also reads it is taken from the bypass.
	assign list_rd  = byp_q ? byp_data_q : mem_rdata;
	assign rd_page  = list_rd[EW-1:16];
	assign rd_cnt   = list_rd[15:0];

	// Effective page count: zero counts as one, capped at the table size.
	always_comb begin
		if (num_pages == 11'd0) begin
			pages = CW'(1);
		end else if (32'(num_pages) > 32'(MAX_PAGES)) begin
			pages = CW'(MAX_PAGES);
		end else begin
			pages = CW'(num_pages);
		end
	end

	// Field width and least-value base of the current section.
	always_comb begin
		base = 32'd0;
		case (sec_q)
			SEC_HEADER:  w32 = {26'd0, hdr_width(4'(pc_q))};
			SEC_OBJECTS: begin w32 = hdr_q[2];  base = hdr_q[0]; end
			SEC_LENGTH:  begin w32 = hdr_q[4];  base = hdr_q[3]; end
			SEC_REFCNT:  w32 = hdr_q[9];
			SEC_ID:      w32 = hdr_q[10];
			SEC_POS:     w32 = hdr_q[11];
			SEC_COFF:    begin w32 = hdr_q[6];  base = hdr_q[5]; end
			default:     begin w32 = hdr_q[8];  base = hdr_q[7]; end
		endcase
	end

	// Field extraction from the top of the valid bits.
	assign w6      = w32[5:0];
	assign shamt   = fill_q - FW'(w6);
	assign shifted = buf_q >> shamt;
	assign mask    = 32'((33'h1 << w6) - 33'h1);
	assign raw     = shifted[31:0] & mask;
	assign val     = base + raw;
	assign rd_ok   = (32'(lidx_q) < 32'(llen_q)) && (32'(rd_page) < 32'(pages));

	// Next state, result and list writes.
	always_comb begin
		buf_d     = buf_q;
		fill_d    = fill_q;
		sec_d     = sec_q;
		pc_d      = pc_q;
		ref_d     = ref_q;
		cnt_d     = cnt_q;
		roff_d    = roff_q;
		robj_d    = robj_q;
		done_d    = done_q;
		lidx_d    = lidx_q;
		llen_d    = llen_q;
		st_d      = st_q;
		hdr_we    = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = {pc_q, raw[15:0]};
		push      = 1'b0;
		fill_al   = '0;
		push_res.status     = ST_FIELD;
		push_res.section    = sec_q;
		push_res.page_index = 10'(pc_q);
		push_res.ref_index  = ref_q;
		push_res.value      = 32'd0;
		push_res.derived    = 32'd0;

		if (st_q == DS_FETCH) begin
			// Resolve a fetched entry of the shared-reference list.
			if (rd_ok) begin
				pc_d  = rd_page;
				cnt_d = rd_cnt;
				st_d  = DS_RUN;
			end else if (sec_q == SEC_ID) begin
				sec_d  = SEC_POS;
				fill_d = fill_q & ~FW'(7);
				lidx_d = '0;
			end else begin
				sec_d  = SEC_COFF;
				fill_d = fill_q & ~FW'(7);
				pc_d   = '0;
				st_d   = DS_RUN;
			end
		end else if (accept) begin
			case (req_type)
				REQ_BYTE: begin
					push = 1'b1;
					if (32'(fill_q) + 32'd8 <= 32'(BUFFER_BITS)) begin
						buf_d  = {buf_q[BUFFER_BITS-9:0], data_byte};
						fill_d = fill_q + FW'(8);
						push_res.status = ST_TAKEN;
					end else begin
						push_res.status = ST_FULL;
					end
					push_res.value = 32'(fill_d);
				end
				REQ_NEXT: begin
					push = 1'b1;
					if (done_q) begin
						push_res.status = ST_DONE;
					end else if (w32 > 32'd32) begin
						push_res.status = ST_BAD_WIDTH;
						push_res.value  = w32;
					end else if (32'(fill_q) < w32) begin
						push_res.status = ST_NEED_BYTE;
						push_res.value  = w32;
					end else if ((sec_q == SEC_REFCNT) && (raw[31:16] != 16'd0)) begin
						push_res.status = ST_BAD_WIDTH;
						push_res.value  = raw;
					end else begin
						// Consume the field and work out the derived value.
						fill_d = fill_q - FW'(w6);
						push_res.value = val;
						case (sec_q)
							SEC_HEADER: hdr_we = (32'(pc_q) < 32'(HDR_KEEP));
							SEC_OBJECTS: begin
								if (pc_q == '0) begin
									push_res.derived = first_page_first_object;
									robj_d = 32'd1;
								end else begin
									push_res.derived = robj_q;
									robj_d = robj_q + val;
								end
							end
							SEC_LENGTH: begin
								push_res.derived = (roff_q >= hint_offset) ?
									roff_q + hint_length : roff_q;
								roff_d = roff_q + val;
							end
							SEC_REFCNT: begin
								if (raw[15:0] != 16'd0) begin
									mem_we = 1'b1;
									llen_d = llen_q + CW'(1);
								end
							end
							SEC_COFF: begin
								push_res.derived = (val >= hint_offset) ?
									val + hint_length : val;
							end
							default: begin
							end
						endcase

						// Advance to the next field position.
						fill_al = fill_d & ~FW'(7);
						if (sec_q == SEC_HEADER) begin
							if (32'(pc_q) < 32'd12) begin
								pc_d = pc_q + PCW'(1);
							end else begin
								sec_d = SEC_OBJECTS;
								pc_d  = '0;
							end
						end else if ((sec_q == SEC_ID) || (sec_q == SEC_POS)) begin
							if (17'(ref_q) + 17'd1 < 17'(cnt_q)) begin
								ref_d = ref_q + 16'd1;
							end else begin
								ref_d  = 16'd0;
								lidx_d = lidx_q + CW'(1);
								st_d   = DS_FETCH;
							end
						end else if (32'(pc_q) + 32'd1 < 32'(pages)) begin
							pc_d = pc_q + PCW'(1);
						end else if (sec_q == SEC_CLEN) begin
							done_d = 1'b1;
						end else begin
							sec_d  = sec_q + 3'd1;
							fill_d = fill_al;
							pc_d   = '0;
							ref_d  = 16'd0;
							if (sec_q == SEC_OBJECTS) begin
								roff_d = hdr_q[1];
							end
							if (sec_q == SEC_LENGTH) begin
								llen_d = '0;
							end
							if (sec_q == SEC_REFCNT) begin
								lidx_d = '0;
								st_d   = DS_FETCH;
							end
						end
					end
				end
				REQ_RESTART: begin
					buf_d  = '0;
					fill_d = '0;
					sec_d  = SEC_HEADER;
					pc_d   = '0;
					ref_d  = 16'd0;
					roff_d = 32'd0;
					robj_d = 32'd0;
					done_d = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Control and running-sum registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q      <= '0;
			fill_q     <= '0;
			sec_q      <= SEC_HEADER;
			pc_q       <= '0;
			ref_q      <= 16'd0;
			cnt_q      <= 16'd0;
			roff_q     <= 32'd0;
			robj_q     <= 32'd0;
			done_q     <= 1'b0;
			lidx_q     <= '0;
			llen_q     <= '0;
			st_q       <= DS_RUN;
			byp_q      <= 1'b0;
			byp_data_q <= '0;
		end else begin
			buf_q      <= buf_d;
			fill_q     <= fill_d;
			sec_q      <= sec_d;
			pc_q       <= pc_d;
			ref_q      <= ref_d;
			cnt_q      <= cnt_d;
			roff_q     <= roff_d;
			robj_q     <= robj_d;
			done_q     <= done_d;
			lidx_q     <= lidx_d;
			llen_q     <= llen_d;
			st_q       <= st_d;
			byp_q      <= mem_we && (AW'(llen_q) == AW'(lidx_d));
			byp_data_q <= mem_wdata;
		end
	end

	// Header field store.
	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_q[4'(pc_q)] <= raw;
		end
	end

	// List of pages with shared references, in page order.
	pohd_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_PAGES)
	) u_list (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(llen_q)),
		.wdata (mem_wdata),
		.raddr (AW'(lidx_d)),
		.rdata (mem_rdata)
	);

	`POHD_NEVER(a_fill_range, fill_q > FW'(BUFFER_BITS), "bit fill past buffer size")
	`POHD_ASSERT(a_fetch_blocks, (st_q == DS_FETCH) |-> !in_ready, "item taken during list read")
	`POHD_ASSERT(a_ref_in_page, ((st_q == DS_RUN) && ((sec_q == SEC_ID) || (sec_q == SEC_POS))) |-> (ref_q < cnt_q), "reference index past page count")

endmodule

`default_nettype wire
